@@ sv/fccw_pkg.sv @@
// Shared types and constants for the FAT12 cluster chain walker.
`timescale 1ns / 1ps
`default_nettype none

package fccw_pkg;

    localparam int TABLE_BYTES_DEF = 8192;
    localparam int TBL_AW          = 13;
    localparam int CLUSTER_W       = 12;
    localparam int SECTOR_W        = 20;

    localparam logic [CLUSTER_W-1:0] ENTRY_MASK   = 12'hFFF;
    localparam logic [CLUSTER_W-1:0] END_OF_CHAIN = 12'hFF8;
    localparam logic [CLUSTER_W-1:0] FIRST_DATA   = 12'd2;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_START   = 2'd1,
        OP_ADVANCE = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_LOADED  = 2'd1,
        ST_NOCHAIN = 2'd2,
        ST_LOWCLUS = 2'd3
    } t_status;

    typedef enum logic {
        CFG_DATA_START = 1'b0,
        CFG_SPC        = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        K_LOAD,
        K_NOCHAIN,
        K_LOW,
        K_WALK
    } t_kind;

    typedef enum logic {
        S_IDLE,
        S_RESULT
    } t_state;

    typedef struct packed {
        t_op                  op;
        logic [TBL_AW-1:0]    table_address;
        logic [7:0]           table_byte;
        logic [CLUSTER_W-1:0] first_cluster;
    } t_in_word;

    typedef struct packed {
        logic [CLUSTER_W-1:0] cluster;
        logic [SECTOR_W-1:0]  sector_address;
        logic [CLUSTER_W-1:0] next_cluster;
        logic                 last;
        t_status              status;
    } t_out_word;

    // table port: one byte write and one two-byte read request
    typedef struct packed {
        logic              wr_en;
        logic [TBL_AW-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [TBL_AW-1:0] rd_idx;
    } t_tbl_req;

endpackage

`default_nettype wire

@@ sv/fccw_tbl.sv @@
// Allocation table store: even and odd byte banks, reads the byte pair at any index.
`timescale 1ns / 1ps
`default_nettype none

module fccw_tbl import fccw_pkg::*; #(
    parameter int TABLE_BYTES = TABLE_BYTES_DEF
) (
    input  wire logic       i_clk,
    input  wire t_tbl_req   i_req,
    output logic [7:0]      o_lo,
    output logic [7:0]      o_hi
);

    localparam int BANK_DEPTH = (TABLE_BYTES + 1) / 2;
    localparam int BW         = $clog2(BANK_DEPTH);
    localparam logic [TBL_AW:0] LIMIT = (TBL_AW+1)'(TABLE_BYTES);

    logic [7:0] r_even [BANK_DEPTH];
    logic [7:0] r_odd  [BANK_DEPTH];

    logic [7:0] r_even_q;
    logic [7:0] r_odd_q;
    logic       r_swap;
    logic       r_lo_ok;
    logic       r_hi_ok;

    logic [TBL_AW-2:0] half;
    logic [TBL_AW-2:0] even_row;
    logic [TBL_AW:0]   lo_addr;
    logic [TBL_AW:0]   hi_addr;
    logic              wr_ok;

    always_comb begin
        half     = i_req.rd_idx[TBL_AW-1:1];
        // an odd index starts in the odd bank; the high byte is then in the next even row
        even_row = half + (TBL_AW-1)'(i_req.rd_idx[0]);
        lo_addr  = {1'b0, i_req.rd_idx};
        hi_addr  = lo_addr + (TBL_AW+1)'(1);
        wr_ok    = i_req.wr_en && ({1'b0, i_req.wr_addr} < LIMIT);
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok && !i_req.wr_addr[0]) begin
            r_even[i_req.wr_addr[BW:1]] <= i_req.wr_data;
        end
        if (wr_ok && i_req.wr_addr[0]) begin
            r_odd[i_req.wr_addr[BW:1]] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_even_q <= r_even[even_row[BW-1:0]];
            r_odd_q  <= r_odd[half[BW-1:0]];
            r_swap   <= i_req.rd_idx[0];
            r_lo_ok  <= lo_addr < LIMIT;
            r_hi_ok  <= hi_addr < LIMIT;
        end
    end

    // bytes beyond the table read as zero
    always_comb begin
        o_lo = r_lo_ok ? (r_swap ? r_odd_q : r_even_q) : 8'd0;
        o_hi = r_hi_ok ? (r_swap ? r_even_q : r_odd_q) : 8'd0;
    end

endmodule

`default_nettype wire

@@ sv/fat12_cluster_chain_walker.sv @@
// Top level of the FAT12 cluster chain walker.
`timescale 1ns / 1ps
`default_nettype none

// Walks a FAT12 cluster chain held in an on-chip allocation table of TABLE_BYTES bytes.
// Load words write one table byte; start words visit a first cluster; advance words
// visit the cluster the previous visit pointed to. Every accepted word with op 0..2
// gives exactly one result word; op 3 is dropped. For each word, the
// accept cycle issues the byte-pair read to the two table banks, and the next cycle
// forms the 12-bit entry, the sector address and the result. A result waiting at the
// output does not block acceptance; the following word holds in its result cycle
// until the output register frees up. Table bytes are undefined until loaded.
module fat12_cluster_chain_walker import fccw_pkg::*; #(
    parameter int TABLE_BYTES = TABLE_BYTES_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_word      o_out_word,
    input  wire logic      i_cfg_valid,
    output logic           o_cfg_ready,
    input  wire t_cfg_idx  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    t_state                r_state, n_state;
    logic                  r_chain_active, n_chain_active;
    logic [CLUSTER_W-1:0]  r_pending, n_pending;
    logic                  r_out_valid, n_out_valid;
    t_out_word             r_out_word, n_out_word;
    t_kind                 r_kind, n_kind;
    logic [CLUSTER_W-1:0]  r_cluster, n_cluster;
    logic [15:0]           r_data_start;
    logic [7:0]            r_spc;

    t_tbl_req              tbl_req;
    logic [7:0]            tbl_lo;
    logic [7:0]            tbl_hi;

    logic                  in_fire;
    logic [CLUSTER_W-1:0]  visit;
    logic [15:0]           pair;
    logic [CLUSTER_W-1:0]  entry;
    logic [SECTOR_W-1:0]   sector;
    logic                  slot_free;

    fccw_tbl #(
        .TABLE_BYTES(TABLE_BYTES)
    ) u_tbl (
        .i_clk (i_clk),
        .i_req (tbl_req),
        .o_lo  (tbl_lo),
        .o_hi  (tbl_hi)
    );

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_start <= 16'd0;
            r_spc        <= 8'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DATA_START: r_data_start <= i_cfg_data;
                CFG_SPC:        r_spc        <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        in_fire    = i_in_valid && o_in_ready;
        slot_free  = !r_out_valid || i_out_ready;

        visit = (i_in_word.op == OP_START) ? i_in_word.first_cluster : r_pending;

        // byte pair at cluster * 3 / 2
        tbl_req.wr_en   = in_fire && (i_in_word.op == OP_LOAD);
        tbl_req.wr_addr = i_in_word.table_address;
        tbl_req.wr_data = i_in_word.table_byte;
        tbl_req.rd_en   = in_fire;
        tbl_req.rd_idx  = TBL_AW'({1'b0, visit}) + TBL_AW'(visit[CLUSTER_W-1:1]);

        pair   = {tbl_hi, tbl_lo};
        entry  = r_cluster[0] ? pair[15:4] : (pair[11:0] & ENTRY_MASK);
        sector = SECTOR_W'(r_data_start)
               + SECTOR_W'(r_cluster - FIRST_DATA) * SECTOR_W'(r_spc);

        n_state        = r_state;
        n_chain_active = r_chain_active;
        n_pending      = r_pending;
        n_out_valid    = r_out_valid && !i_out_ready;
        n_out_word     = r_out_word;
        n_kind         = r_kind;
        n_cluster      = r_cluster;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_cluster = visit;
                    case (i_in_word.op)
                        OP_LOAD: begin
                            n_kind  = K_LOAD;
                            n_state = S_RESULT;
                        end
                        OP_START: begin
                            n_kind  = (visit < FIRST_DATA) ? K_LOW : K_WALK;
                            n_state = S_RESULT;
                        end
                        OP_ADVANCE: begin
                            if (!r_chain_active) begin
                                n_kind = K_NOCHAIN;
                            end else begin
                                n_kind = (visit < FIRST_DATA) ? K_LOW : K_WALK;
                            end
                            n_state = S_RESULT;
                        end
                        default: ;
                    endcase
                end
            end
            S_RESULT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    n_out_word  = '0;
                    case (r_kind)
                        K_LOAD: begin
                            n_out_word.status = ST_LOADED;
                        end
                        K_NOCHAIN: begin
                            n_out_word.status = ST_NOCHAIN;
                        end
                        K_LOW: begin
                            n_out_word.cluster = r_cluster;
                            n_out_word.last    = 1'b1;
                            n_out_word.status  = ST_LOWCLUS;
                            n_chain_active     = 1'b0;
                        end
                        K_WALK: begin
                            n_out_word.cluster        = r_cluster;
                            n_out_word.sector_address = sector;
                            n_out_word.next_cluster   = entry;
                            n_out_word.last           = (entry >= END_OF_CHAIN);
                            n_out_word.status         = ST_OK;
                            n_pending                 = entry;
                            n_chain_active            = (entry < END_OF_CHAIN);
                        end
                        default: ;
                    endcase
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_chain_active <= 1'b0;
            r_pending      <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_chain_active <= n_chain_active;
            r_pending      <= n_pending;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
        r_kind     <= n_kind;
        r_cluster  <= n_cluster;
    end

    a_result_from_result_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_RESULT))
        else $error("result word appeared without a result cycle");

    a_no_accept_in_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESULT) |-> !o_in_ready)
        else $error("input accepted while a result is being formed");

    a_last_ends_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.last) |-> !r_chain_active)
        else $error("chain still active after a last word");

    a_nochain_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status == ST_NOCHAIN) |-> !r_chain_active)
        else $error("no-chain status reported while a chain is active");

endmodule

`default_nettype wire

@@ verif/tb_fat12_cluster_chain_walker.sv @@
// Self-checking testbench for the FAT12 cluster chain walker.
`timescale 1ns / 1ps

module tb_fat12_cluster_chain_walker;
    import fccw_pkg::*;

    // Mirrors the table, chain and registers; predicts each visit result.
    class chain_visit_board;
        bit [7:0]    tbl [TABLE_BYTES_DEF];
        bit          written [TABLE_BYTES_DEF];
        bit [11:0]   pend;
        bit          active;
        bit [15:0]   data_start;
        bit [7:0]    spc;
        t_out_word   due_results[$];
        int          errors;

        function new();
            pend       = '0;
            active     = 1'b0;
            data_start = '0;
            spc        = 8'd1;
            errors     = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, bit [15:0] d);
            if (idx == CFG_DATA_START)
                data_start = d;
            else
                spc = d[7:0];
        endfunction

        function t_out_word visit_cluster(bit [11:0] c);
            t_out_word   r;
            int          idx;
            bit [15:0]   pair;
            bit [11:0]   nxt;
            int unsigned sec;
            r = '0;
            r.cluster = c;
            if (c < FIRST_DATA) begin
                active   = 1'b0;
                r.last   = 1'b1;
                r.status = ST_LOWCLUS;
                return r;
            end
            idx  = int'(c) + int'(c >> 1);
            pair = {tbl[idx + 1], tbl[idx]};
            nxt  = c[0] ? pair[15:4] : pair[11:0];
            sec  = int'(data_start) + (int'(c) - 2) * int'(spc);
            r.sector_address = sec[SECTOR_W-1:0];
            r.next_cluster   = nxt;
            r.last           = (nxt >= END_OF_CHAIN);
            r.status         = ST_OK;
            pend   = nxt;
            active = !r.last;
            return r;
        endfunction

        function void note_word(t_in_word w);
            t_out_word r;
            r = '0;
            case (w.op)
                OP_LOAD: begin
                    if (int'(w.table_address) < TABLE_BYTES_DEF) begin
                        tbl[w.table_address]     = w.table_byte;
                        written[w.table_address] = 1'b1;
                    end
                    r.status = ST_LOADED;
                    due_results.push_back(r);
                end
                OP_START: begin
                    due_results.push_back(visit_cluster(w.first_cluster));
                end
                OP_ADVANCE: begin
                    if (!active) begin
                        r.status = ST_NOCHAIN;
                        due_results.push_back(r);
                    end else begin
                        due_results.push_back(visit_cluster(pend));
                    end
                end
                default: ;
            endcase
        endfunction

        task report(string what, longint got, longint want);
            errors++;
            $display("mismatch %s: got %0h want %0h", what, got, want);
        endtask

        task check_result(t_out_word got);
            t_out_word want;
            if (due_results.size() == 0) begin
                report("unexpected result", longint'(got), 0);
                return;
            end
            want = due_results.pop_front();
            if (got.cluster !== want.cluster)
                report("cluster", got.cluster, want.cluster);
            if (got.sector_address !== want.sector_address)
                report("sector_address", got.sector_address, want.sector_address);
            if (got.next_cluster !== want.next_cluster)
                report("next_cluster", got.next_cluster, want.next_cluster);
            if (got.last !== want.last)
                report("last", got.last, want.last);
            if (got.status !== want.status)
                report("status", got.status, want.status);
        endtask
    endclass

    localparam int ITEMS  = 1250;
    localparam int PHASES = 6;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    t_in_word    i_in_word   = '0;
    logic        i_out_ready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    t_cfg_idx    i_cfg_index = CFG_DATA_START;
    logic [15:0] i_cfg_data  = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    t_out_word   o_out_word;
    logic        o_cfg_ready;

    chain_visit_board board = new();
    bit  no_idle    = 1'b0;
    int  sent       = 0;
    int  stall_left = 0;

    fat12_cluster_chain_walker uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_result(o_out_word);
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else begin
            i_out_ready <= 1'b1;
            stall_left  <= pick_gap();
        end
    end

    task automatic send_word(t_in_word w);
        int gap;
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_word(w);
        if (w.op != OP_NONE)
            sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // drop valid and let every outstanding result drain
    task automatic drain();
        if (i_in_valid) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        while (board.due_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, bit [15:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_reg(idx, d);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_byte(int a, bit [7:0] b);
        t_in_word w;
        w.op            = OP_LOAD;
        w.table_address = a[TBL_AW-1:0];
        w.table_byte    = b;
        w.first_cluster = 12'($urandom);
        send_word(w);
    endtask

    // rewrite the 12-bit entry of c, keeping the neighbour's nibble
    task automatic set_entry(bit [11:0] c, bit [11:0] v);
        int        idx;
        bit [15:0] pair;
        idx  = int'(c) + int'(c >> 1);
        pair = {board.tbl[idx + 1], board.tbl[idx]};
        if (c[0])
            pair[15:4] = v;
        else
            pair[11:0] = v;
        load_byte(idx, pair[7:0]);
        load_byte(idx + 1, pair[15:8]);
    endtask

    // a visit must never touch a table byte that was never loaded
    task automatic guard_cluster(bit [11:0] c);
        int idx;
        if (c >= FIRST_DATA) begin
            idx = int'(c) + int'(c >> 1);
            for (int k = 0; k < 2; k++)
                if (!board.written[idx + k])
                    load_byte(idx + k, 8'($urandom));
        end
    endtask

    task automatic start_chain(bit [11:0] c);
        t_in_word w;
        guard_cluster(c);
        w.op            = OP_START;
        w.table_address = 13'($urandom);
        w.table_byte    = 8'($urandom);
        w.first_cluster = c;
        send_word(w);
    endtask

    task automatic advance();
        t_in_word w;
        if (board.active)
            guard_cluster(board.pend);
        w.op            = OP_ADVANCE;
        w.table_address = 13'($urandom);
        w.table_byte    = 8'($urandom);
        w.first_cluster = 12'($urandom);
        send_word(w);
    endtask

    // lay down a short chain, then walk it and a little past its end
    task automatic walk_chain();
        int        len;
        int        cl [6];
        int        cand;
        bit        dup;
        bit [11:0] tail;
        int        r;
        len   = $urandom_range(1, 6);
        cl[0] = $urandom_range(2, 4095);
        for (int i = 1; i < len; i++) begin
            do begin
                if ($urandom_range(0, 3) == 0 && cl[i-1] < 4095)
                    cand = cl[i-1] + 1;
                else
                    cand = $urandom_range(2, 4095);
                dup = 1'b0;
                for (int j = 0; j < i; j++)
                    if (cl[j] == cand)
                        dup = 1'b1;
            end while (dup);
            cl[i] = cand;
        end
        r = $urandom_range(0, 99);
        if (r < 70)
            tail = 12'($urandom_range(12'hFF8, 12'hFFF));
        else if (r < 85)
            tail = 12'($urandom_range(0, 1));
        else
            tail = 12'(cl[0]);
        for (int i = 0; i < len; i++)
            set_entry(12'(cl[i]), (i < len - 1) ? 12'(cl[i+1]) : tail);
        start_chain(12'(cl[0]));
        repeat (len - 1 + $urandom_range(0, 2))
            advance();
    endtask

    task automatic noise_word();
        t_in_word    w;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        w   = raw[$bits(t_in_word)-1:0];
        case (w.op)
            OP_START:   start_chain(w.first_cluster);
            OP_ADVANCE: advance();
            default:    send_word(w);
        endcase
    endtask

    task automatic directed_words();
        t_in_word w;
        load_byte(8191, 8'hFF);
        load_byte(0, 8'h00);
        start_chain(12'd0);
        start_chain(12'd1);
        advance();
        w    = '1;
        w.op = OP_NONE;
        send_word(w);
        set_entry(12'd2, 12'd3);
        set_entry(12'd3, 12'hFFF);
        start_chain(12'd2);
        advance();
        advance();
        set_entry(12'd4095, 12'hFF8);
        start_chain(12'd4095);
        set_entry(12'd4094, 12'd1);
        start_chain(12'd4094);
        advance();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                drain();
                no_idle = 1'b0;
                repeat (8) @(posedge i_clk);
                case (p)
                    1: begin
                        write_reg(CFG_DATA_START, 16'hFFFF);
                        write_reg(CFG_SPC, 16'd128);
                    end
                    2: begin
                        write_reg(CFG_DATA_START, 16'd0);
                        write_reg(CFG_SPC, 16'd1);
                    end
                    default: begin
                        write_reg(CFG_DATA_START, 16'($urandom));
                        write_reg(CFG_SPC, 16'($urandom_range(1, 128)));
                    end
                endcase
                no_idle = (p == 3);
            end else begin
                directed_words();
            end
            while (sent < (p + 1) * ITEMS / PHASES) begin
                if ($urandom_range(0, 39) == 0)
                    drain();
                if ($urandom_range(0, 99) < 65)
                    walk_chain();
                else
                    noise_word();
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (board.due_results.size() != 0)
            board.report("results outstanding", board.due_results.size(), 0);
        if (board.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/fccw_pkg.sv
sv/fccw_tbl.sv
sv/fat12_cluster_chain_walker.sv
verif/tb_fat12_cluster_chain_walker.sv
